// ===== rtl/gasp_pkg.sv =====
// Package for the glyph atlas shelf packer: widths, codes, state and result
// structs, and the saturating and sizing helpers. No dependencies.
`default_nettype none

package gasp_pkg;

    localparam int COORD_BITS     = 16;
    localparam int GLYPH_BITS     = 8;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int WIDE_BITS      = COORD_BITS + 1;
    localparam int SIZE_BITS      = CFG_DATA_BITS + COORD_BITS;

    typedef logic [COORD_BITS-1:0]     coord_t;
    typedef logic [WIDE_BITS-1:0]      wide_t;
    typedef logic [GLYPH_BITS-1:0]     glyph_t;
    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [SIZE_BITS-1:0]      size_wide_t;

    localparam cfg_index_t CFG_IDX_INIT_WIDTH  = cfg_index_t'(0);
    localparam cfg_index_t CFG_IDX_INIT_HEIGHT = cfg_index_t'(1);
    localparam cfg_data_t  INIT_SIZE_RESET     = cfg_data_t'(256);

    // Quadrant being filled, one-hot.
    typedef enum logic [3:0] {
        QUAD_TL = 4'b0001,
        QUAD_TR = 4'b0010,
        QUAD_BL = 4'b0100,
        QUAD_BR = 4'b1000
    } quad_t;

    typedef struct packed {
        quad_t  quadrant;
        coord_t cursor_x;
        coord_t cursor_y;
        coord_t shelf_x;
        coord_t shelf_bottom;
        coord_t region_x;
        coord_t region_y;
        coord_t region_w;
        coord_t region_h;
        coord_t cur_width;
        coord_t cur_height;
    } pack_state_t;

    typedef struct packed {
        coord_t place_x;
        coord_t place_y;
        coord_t atlas_width;
        coord_t atlas_height;
        logic   grew;
        logic   full_res;
    } place_res_t;

    function automatic coord_t sat_coord(wide_t v);
        return v[COORD_BITS] ? {COORD_BITS{1'b1}} : v[COORD_BITS-1:0];
    endfunction

    function automatic wide_t widen(coord_t v);
        return {1'b0, v};
    endfunction

    function automatic wide_t widen_glyph(glyph_t v);
        return wide_t'(v);
    endfunction

    // Register value to atlas size: zero reads as one, clamp to coordinate range.
    function automatic coord_t size_from_cfg(cfg_data_t v);
        size_wide_t w;
        size_wide_t m;
        w = size_wide_t'(v);
        m = size_wide_t'({COORD_BITS{1'b1}});
        if (w == '0) begin
            w = size_wide_t'(1);
        end
        return (w > m) ? {COORD_BITS{1'b1}} : w[COORD_BITS-1:0];
    endfunction

    function automatic pack_state_t restart_state(cfg_data_t iw, cfg_data_t ih);
        pack_state_t s;
        s              = '0;
        s.quadrant     = QUAD_TL;
        s.region_w     = size_from_cfg(iw);
        s.region_h     = size_from_cfg(ih);
        s.cur_width    = s.region_w;
        s.cur_height   = s.region_h;
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gasp_place.sv =====
// Placement logic: one rectangle against the packer state, giving the next
// state and the result. Purely combinational. Uses gasp_pkg.
`default_nettype none

module gasp_place
    import gasp_pkg::*;
(
    input  pack_state_t st,
    input  glyph_t      glyph_width,
    input  glyph_t      glyph_height,
    output pack_state_t st_next,
    output place_res_t  res
);

    wide_t  gw;
    wide_t  gh;
    logic   wrap;
    coord_t cx0;
    coord_t cy0;
    wide_t  py_h;
    coord_t sb1;
    logic   spill;
    coord_t rx;
    coord_t ry;
    logic   full;

    always_comb begin
        gw = widen_glyph(glyph_width);
        gh = widen_glyph(glyph_height);

        // New shelf when the rectangle reaches the region's right edge.
        wrap = (widen(st.cursor_x) + gw) >= (widen(st.region_x) + widen(st.region_w));
        cx0  = wrap ? st.shelf_x : st.cursor_x;
        cy0  = wrap ? st.shelf_bottom : st.cursor_y;
        py_h = widen(cy0) + gh;
        sb1  = (widen(st.shelf_bottom) < py_h) ? sat_coord(py_h) : st.shelf_bottom;
        spill = widen(sb1) >= (widen(st.region_y) + widen(st.region_h));

        st_next              = st;
        st_next.cursor_x     = sat_coord(widen(cx0) + gw);
        st_next.cursor_y     = cy0;
        st_next.shelf_bottom = sb1;

        res              = '0;
        res.place_x      = cx0;
        res.place_y      = cy0;
        res.atlas_width  = st.cur_width;
        res.atlas_height = st.cur_height;

        rx   = st.region_x;
        ry   = st.region_y;
        full = 1'b0;

        if (spill) begin
            case (st.quadrant)
                QUAD_TL, QUAD_BR: begin
                    full = st.cur_width[COORD_BITS-1] | st.cur_height[COORD_BITS-1];
                    // Double; the old size is the new half.
                    st_next.cur_width  = {st.cur_width[COORD_BITS-2:0], 1'b0};
                    st_next.cur_height = {st.cur_height[COORD_BITS-2:0], 1'b0};
                    st_next.region_w   = st.cur_width;
                    st_next.region_h   = st.cur_height;
                    st_next.quadrant   = QUAD_TR;
                    rx = st.cur_width;
                    ry = '0;
                    res.grew = 1'b1;
                end
                QUAD_TR: begin
                    st_next.quadrant = QUAD_BL;
                    rx = '0;
                    ry = st.cur_height >> 1;
                end
                QUAD_BL: begin
                    st_next.quadrant = QUAD_BR;
                    rx = st.cur_width >> 1;
                    ry = st.cur_height >> 1;
                end
                default: begin
                    rx = st.region_x;
                    ry = st.region_y;
                end
            endcase

            st_next.region_x     = rx;
            st_next.region_y     = ry;
            st_next.shelf_x      = rx;
            st_next.cursor_y     = ry;
            st_next.cursor_x     = sat_coord(widen(rx) + gw);
            st_next.shelf_bottom = sat_coord(widen(ry) + gh);
            res.place_x          = rx;
            res.place_y          = ry;
            res.atlas_width      = st_next.cur_width;
            res.atlas_height     = st_next.cur_height;

            if (full) begin
                st_next          = st;
                res              = '0;
                res.atlas_width  = st.cur_width;
                res.atlas_height = st.cur_height;
                res.full_res     = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gasp_state.sv =====
// Packer state and size registers; a size register write restarts the packer.
// Uses gasp_pkg.
`default_nettype none

module gasp_state
    import gasp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  cfg_index_t  cfg_index,
    input  cfg_data_t   cfg_data,
    input  logic        step_en,
    input  pack_state_t st_next,
    output pack_state_t st
);

    cfg_data_t   init_w_reg;
    cfg_data_t   init_w_next;
    cfg_data_t   init_h_reg;
    cfg_data_t   init_h_next;
    pack_state_t st_reg;
    logic        known_index;

    always_comb begin
        init_w_next = init_w_reg;
        init_h_next = init_h_reg;
        known_index = 1'b0;
        case (cfg_index)
            CFG_IDX_INIT_WIDTH: begin
                init_w_next = cfg_data;
                known_index = 1'b1;
            end
            CFG_IDX_INIT_HEIGHT: begin
                init_h_next = cfg_data;
                known_index = 1'b1;
            end
            default: begin
                known_index = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_w_reg <= INIT_SIZE_RESET;
            init_h_reg <= INIT_SIZE_RESET;
            st_reg     <= restart_state(INIT_SIZE_RESET, INIT_SIZE_RESET);
        end else if (cfg_we && known_index) begin
            init_w_reg <= init_w_next;
            init_h_reg <= init_h_next;
            st_reg     <= restart_state(init_w_next, init_h_next);
        end else if (step_en) begin
            st_reg <= st_next;
        end
    end

    assign st = st_reg;

endmodule

`default_nettype wire

// ===== rtl/glyph_atlas_shelf_packer.sv =====
// Top level of the glyph atlas shelf packer: input register, placement
// logic, state registers and result register. Uses gasp_pkg, gasp_place, gasp_state.
`default_nettype none

// Glyph atlas shelf packer. Each input beat carries one rectangle (glyph
// width and height); each output beat gives its position, the atlas size
// after the placement, a grew flag when the atlas doubled and a full flag
// when doubling would leave the coordinate range (the position is then 0
// and nothing changes). One beat is taken every clock cycle unless the
// result side stalls; a result passes through the input register, then the
// result register, and the state update for an item lands in the same cycle as
// its result is registered, so the next item sees it. The input side keeps
// moving while a result waits, as long as the result register is free or
// drains that cycle. Writes to initial_width (index 0) or initial_height
// (index 1) restart the packer at once; cfg_ready is always high, and the
// port is meant to be written only while no beat is in flight. Other
// indexes are ignored. A size register of zero acts as one.
module glyph_atlas_shelf_packer
    import gasp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  glyph_t     s_glyph_width,
    input  glyph_t     s_glyph_height,

    output logic       m_valid,
    input  logic       m_ready,
    output coord_t     m_place_x,
    output coord_t     m_place_y,
    output coord_t     m_atlas_width,
    output coord_t     m_atlas_height,
    output logic       m_grew,
    output logic       m_full_res,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  cfg_data_t  cfg_data
);

    // Input register.
    logic        in_valid_reg;
    glyph_t      gw_reg;
    glyph_t      gh_reg;

    // Result register.
    logic        out_valid_reg;
    place_res_t  out_res_reg;

    pack_state_t st;
    pack_state_t st_next;
    place_res_t  res;
    logic        out_free;
    logic        advance;

    // The result register can take a new beat when empty or draining now.
    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            gw_reg <= s_glyph_width;
            gh_reg <= s_glyph_height;
        end
    end

    gasp_place u_place (
        .st           (st),
        .glyph_width  (gw_reg),
        .glyph_height (gh_reg),
        .st_next      (st_next),
        .res          (res)
    );

    // State advances when a placement moves into the result register, unless a size register write restarts it.
    gasp_state u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step_en   (advance),
        .st_next   (st_next),
        .st        (st)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_place_x      = out_res_reg.place_x;
    assign m_place_y      = out_res_reg.place_y;
    assign m_atlas_width  = out_res_reg.atlas_width;
    assign m_atlas_height = out_res_reg.atlas_height;
    assign m_grew         = out_res_reg.grew;
    assign m_full_res     = out_res_reg.full_res;

endmodule

`default_nettype wire

// ===== rtl/gasp_checker.sv =====
// Port-level checker for the glyph atlas shelf packer, bound to the top
// level. Uses gasp_pkg.
`default_nettype none

module gasp_checker
    import gasp_pkg::*;
(
    input wire logic   aclk,
    input wire logic   aresetn,
    input wire logic   m_valid,
    input wire logic   m_ready,
    input wire coord_t m_place_x,
    input wire coord_t m_atlas_width,
    input wire coord_t m_atlas_height,
    input wire logic   m_grew,
    input wire logic   m_full_res
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_place_x) && $stable(m_grew))
        else $error("result beat changed while stalled");

    // A full result never reports growth and has place_x zero.
    a_full_no_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_full_res |-> !m_grew && m_place_x == '0)
        else $error("full result carries growth or a position");

    // A placement's x always lies inside the atlas width.
    a_x_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_full_res |-> m_place_x < m_atlas_width)
        else $error("placement left of atlas right edge violated");

    // A doubled atlas has even dimensions.
    a_grew_even: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_grew |-> !m_atlas_width[0] && !m_atlas_height[0])
        else $error("grown atlas has odd size");

endmodule

bind glyph_atlas_shelf_packer gasp_checker u_gasp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_place_x      (m_place_x),
    .m_atlas_width  (m_atlas_width),
    .m_atlas_height (m_atlas_height),
    .m_grew         (m_grew),
    .m_full_res     (m_full_res)
);

`default_nettype wire

// ===== bench/glyph_atlas_shelf_packer_tb.sv =====
// Self-checking bench for glyph_atlas_shelf_packer: directed and random
// rectangles checked beat by beat against an in-bench shelf packer.
// Depends on gasp_pkg (types, quadrant codes, register indexes) and the RTL top.
`timescale 1ns / 100ps

module glyph_atlas_shelf_packer_tb;

    import gasp_pkg::*;

    // Unused register slots: writes there must leave the packer alone.
    localparam cfg_index_t CFG_IDX_SPARE_A = cfg_index_t'(2);
    localparam cfg_index_t CFG_IDX_SPARE_B = cfg_index_t'(3);

    // Glyph size mixes for the random part.
    localparam int GEN_SMALL = 0;   // mostly small glyphs, some extremes
    localparam int GEN_TALL  = 1;   // tall glyphs, climbs the shelf bottom fast
    localparam int GEN_ANY   = 2;   // uniform over the whole field range

    // Pacing profiles.
    localparam int PACE_NONE     = 0;
    localparam int PACE_SENDER   = 1;
    localparam int PACE_RECEIVER = 2;
    localparam int PACE_BOTH     = 3;

    localparam int HOLD_CYCLES   = 200;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 4;     // input reg + result reg, plus margin
    localparam int QUIET_LIMIT   = 4000;  // cycles with no beat on any channel

    // Wide enough for coordinate sums and doubling without wrap.
    typedef logic [COORD_BITS+1:0] span_t;
    localparam span_t COORD_TOP = span_t'({COORD_BITS{1'b1}});

    typedef struct packed {
        glyph_t w;
        glyph_t h;
    } glyph_pair_t;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;

    logic       s_valid        = 1'b0;
    logic       s_ready;
    glyph_t     s_glyph_width  = '0;
    glyph_t     s_glyph_height = '0;

    logic       m_valid;
    logic       m_ready = 1'b0;
    coord_t     m_place_x;
    coord_t     m_place_y;
    coord_t     m_atlas_width;
    coord_t     m_atlas_height;
    logic       m_grew;
    logic       m_full_res;

    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = '0;
    cfg_data_t  cfg_data  = '0;

    glyph_atlas_shelf_packer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_glyph_width  (s_glyph_width),
        .s_glyph_height (s_glyph_height),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_place_x      (m_place_x),
        .m_place_y      (m_place_y),
        .m_atlas_width  (m_atlas_width),
        .m_atlas_height (m_atlas_height),
        .m_grew         (m_grew),
        .m_full_res     (m_full_res),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 0;
    end

    // ------------------------------------------------------------------
    // Shelf packer model, held by the bench
    // ------------------------------------------------------------------
    glyph_pair_t glyph_q[$];       // rectangles waiting to be offered
    place_res_t  placement_q[$];   // placements expected on the result side
    pack_state_t shelf;            // packer state as the bench sees it
    cfg_data_t   size_w_reg;
    cfg_data_t   size_h_reg;

    int          idle_pct  = 0;    // sender: chance of a gap per free slot
    int          stall_pct = 0;    // receiver: chance of ready low per cycle
    int          hold_req  = 0;    // bump to start one long receiver hold-off
    int          mismatch_cnt = 0;

    function automatic coord_t clip(span_t v);
        return (v > COORD_TOP) ? coord_t'(COORD_TOP) : coord_t'(v);
    endfunction

    // A size register of zero stands for one.
    function automatic coord_t reg_to_size(cfg_data_t v);
        return (v == '0) ? coord_t'(1) : coord_t'(v);
    endfunction

    function automatic void restart_shelf();
        shelf              = '0;
        shelf.quadrant     = QUAD_TL;
        shelf.region_w     = reg_to_size(size_w_reg);
        shelf.region_h     = reg_to_size(size_h_reg);
        shelf.cur_width    = shelf.region_w;
        shelf.cur_height   = shelf.region_h;
    endfunction

    function automatic void load_size_reg(cfg_index_t idx, cfg_data_t val);
        case (idx)
            CFG_IDX_INIT_WIDTH: begin
                size_w_reg = val;
                restart_shelf();
            end
            CFG_IDX_INIT_HEIGHT: begin
                size_h_reg = val;
                restart_shelf();
            end
            default: begin
            end
        endcase
    endfunction

    // Place one rectangle, advance the model, return the expected beat.
    function automatic place_res_t place_glyph(glyph_t gw, glyph_t gh);
        span_t      cx, cy, sx, sb, px, py;
        span_t      rx, ry, rw, rh, aw, ah;
        quad_t      nq;
        logic       grown;
        place_res_t r;
        cx = span_t'(shelf.cursor_x);
        cy = span_t'(shelf.cursor_y);
        sx = span_t'(shelf.shelf_x);
        sb = span_t'(shelf.shelf_bottom);
        rx = span_t'(shelf.region_x);
        ry = span_t'(shelf.region_y);
        rw = span_t'(shelf.region_w);
        rh = span_t'(shelf.region_h);
        aw = span_t'(shelf.cur_width);
        ah = span_t'(shelf.cur_height);
        nq = shelf.quadrant;
        grown = 1'b0;

        // would reach the right edge: open a new shelf
        if (cx + span_t'(gw) >= rx + rw) begin
            cx = sx;
            cy = sb;
        end
        px = cx;
        py = cy;
        cx = span_t'(clip(cx + span_t'(gw)));
        if (sb < py + span_t'(gh)) begin
            sb = span_t'(clip(py + span_t'(gh)));
        end

        // shelf past the bottom: move to the next quadrant
        if (sb >= ry + rh) begin
            if (nq == QUAD_TL || nq == QUAD_BR) begin
                if ((aw << 1) > COORD_TOP || (ah << 1) > COORD_TOP) begin
                    // atlas full: reject, state untouched
                    r.place_x      = '0;
                    r.place_y      = '0;
                    r.atlas_width  = shelf.cur_width;
                    r.atlas_height = shelf.cur_height;
                    r.grew         = 1'b0;
                    r.full_res     = 1'b1;
                    return r;
                end
                aw    = aw << 1;
                ah    = ah << 1;
                rw    = aw >> 1;
                rh    = ah >> 1;
                grown = 1'b1;
                nq    = QUAD_TR;
                rx    = aw >> 1;
                ry    = '0;
            end else if (nq == QUAD_TR) begin
                nq = QUAD_BL;
                rx = '0;
                ry = ah >> 1;
            end else begin
                nq = QUAD_BR;
                rx = aw >> 1;
                ry = ah >> 1;
            end
            px = rx;
            py = ry;
            cy = ry;
            sx = rx;
            cx = span_t'(clip(rx + span_t'(gw)));
            sb = span_t'(clip(ry + span_t'(gh)));
        end

        shelf.quadrant     = nq;
        shelf.cursor_x     = coord_t'(cx);
        shelf.cursor_y     = coord_t'(cy);
        shelf.shelf_x      = coord_t'(sx);
        shelf.shelf_bottom = coord_t'(sb);
        shelf.region_x     = coord_t'(rx);
        shelf.region_y     = coord_t'(ry);
        shelf.region_w     = coord_t'(rw);
        shelf.region_h     = coord_t'(rh);
        shelf.cur_width    = coord_t'(aw);
        shelf.cur_height   = coord_t'(ah);

        r.place_x      = coord_t'(px);
        r.place_y      = coord_t'(py);
        r.atlas_width  = coord_t'(aw);
        r.atlas_height = coord_t'(ah);
        r.grew         = grown;
        r.full_res     = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: offers queued rectangles, predicts on every accepted
    // beat, and tracks register writes so the model restarts with the block.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_glyphs
        glyph_pair_t nxt;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            size_w_reg  = INIT_SIZE_RESET;
            size_h_reg  = INIT_SIZE_RESET;
            restart_shelf();
        end else begin
            if (cfg_valid && cfg_ready) begin
                load_size_reg(cfg_index, cfg_data);
            end
            if (s_valid && s_ready) begin
                placement_q.push_back(place_glyph(s_glyph_width, s_glyph_height));
            end
            // valid only drops or moves on once the current beat is taken
            if (!s_valid || s_ready) begin
                if (glyph_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    nxt = glyph_q.pop_front();
                    s_valid        <= 1'b1;
                    s_glyph_width  <= nxt.w;
                    s_glyph_height <= nxt.h;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request so the
    // pipeline fills and back-pressures the input.
    // ------------------------------------------------------------------
    int hold_seen = 0;
    int hold_left = 0;

    always @(posedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge aclk) begin : watch_results
        place_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (placement_q.size() == 0) begin
                $error("result beat with nothing expected: x=%0d y=%0d",
                       m_place_x, m_place_y);
                mismatch_cnt++;
            end else begin
                want = placement_q.pop_front();
                check_field("place_x",      want.place_x,      m_place_x);
                check_field("place_y",      want.place_y,      m_place_y);
                check_field("atlas_width",  want.atlas_width,  m_atlas_width);
                check_field("atlas_height", want.atlas_height, m_atlas_height);
                check_field("grew",         want.grew,         m_grew);
                check_field("full_res",     want.full_res,     m_full_res);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long with no beat on any channel ends the run.
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("glyph_atlas_shelf_packer_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_glyph(input int w, input int h);
        glyph_pair_t g;
        g.w = glyph_t'(w);
        g.h = glyph_t'(h);
        glyph_q.push_back(g);
    endtask

    function automatic glyph_pair_t random_glyph(int mode);
        glyph_pair_t g;
        int          roll;
        roll = $urandom_range(99);
        case (mode)
            GEN_TALL: begin
                g.w = glyph_t'($urandom_range(0, 255));
                g.h = glyph_t'($urandom_range(192, 255));
            end
            GEN_ANY: begin
                g.w = glyph_t'($urandom_range(0, 255));
                g.h = glyph_t'($urandom_range(0, 255));
            end
            default: begin
                if (roll < 80) begin
                    g.w = glyph_t'($urandom_range(1, 24));
                    g.h = glyph_t'($urandom_range(1, 24));
                end else if (roll < 90) begin
                    g.w = glyph_t'($urandom_range(0, 255));
                    g.h = glyph_t'($urandom_range(0, 255));
                end else if (roll < 95) begin
                    // degenerate: zero in one dimension
                    g.w = (roll & 1) ? glyph_t'(0) : glyph_t'($urandom_range(0, 255));
                    g.h = (roll & 1) ? glyph_t'($urandom_range(0, 255)) : glyph_t'(0);
                end else begin
                    g.w = '1;
                    g.h = glyph_t'($urandom_range(0, 255));
                end
            end
        endcase
        return g;
    endfunction

    task automatic set_pacing(input int profile);
        case (profile)
            PACE_SENDER: begin
                idle_pct  <= 57;
                stall_pct <= 0;
            end
            PACE_RECEIVER: begin
                idle_pct  <= 0;
                stall_pct <= 57;
            end
            PACE_BOTH: begin
                idle_pct  <= 11;
                stall_pct <= 11;
            end
            default: begin
                idle_pct  <= 0;
                stall_pct <= 0;
            end
        endcase
    endtask

    // Block is idle once nothing is queued, offered or outstanding.
    // Checked mid-cycle so the edge updates of the driver have landed.
    task automatic drain_and_settle();
        while (glyph_q.size() != 0 || s_valid || placement_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input cfg_data_t val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int        n_items;
        int        gen_mode;
        cfg_data_t w_reg;
        cfg_data_t h_reg;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, reset sizes 256x256: zero and full-range glyphs, a shelf
        // wrap at the right edge, growth out of top-left and moves through
        // the other quadrants with 255x255 glyphs.
        set_pacing(PACE_BOTH);
        queue_glyph(0, 0);
        queue_glyph(255, 255);
        queue_glyph(1, 1);
        queue_glyph(255, 0);
        queue_glyph(0, 255);
        queue_glyph(255, 255);
        queue_glyph(255, 255);
        queue_glyph(128, 1);
        queue_glyph(255, 255);
        queue_glyph(255, 255);
        queue_glyph(255, 255);
        queue_glyph(255, 255);
        drain_and_settle();

        // Writes to unused slots must not restart the packer.
        cfg_write(CFG_IDX_SPARE_A, 16'hFFFF);
        cfg_write(CFG_IDX_SPARE_B, 16'h5A5A);
        queue_glyph(7, 9);
        queue_glyph(255, 255);
        drain_and_settle();

        // Zero size registers act as 1x1: growth on nearly every beat.
        cfg_write(CFG_IDX_INIT_WIDTH, 16'h0000);
        cfg_write(CFG_IDX_INIT_HEIGHT, 16'h0000);
        queue_glyph(0, 0);
        queue_glyph(1, 1);
        queue_glyph(0, 1);
        queue_glyph(1, 0);
        queue_glyph(255, 255);
        queue_glyph(2, 2);
        drain_and_settle();

        // Random phases, each from a fresh restart.
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin w_reg = 16'd256;   h_reg = 16'd256;   gen_mode = GEN_SMALL; n_items = 300; end
                1: begin w_reg = 16'd16;    h_reg = 16'd16;    gen_mode = GEN_SMALL; n_items = 200; end
                // 1 wide, full height: nearly every beat opens a shelf, so the shelf
                // bottom climbs to saturation and the atlas runs full
                2: begin w_reg = 16'd1;     h_reg = 16'hFFFF;  gen_mode = GEN_TALL;  n_items = 300; end
                3: begin w_reg = 16'd0;     h_reg = 16'd0;     gen_mode = GEN_ANY;   n_items = 100; end
                4: begin w_reg = 16'hFFFF;  h_reg = 16'd1;     gen_mode = GEN_ANY;   n_items = 80;  end
                5: begin w_reg = 16'h8000;  h_reg = 16'h8000;  gen_mode = GEN_ANY;   n_items = 150; end
                6: begin
                    w_reg    = cfg_data_t'($urandom_range(1, 200));
                    h_reg    = cfg_data_t'($urandom_range(1, 200));
                    gen_mode = GEN_SMALL;
                    n_items  = 200;
                end
                default: begin w_reg = 16'd64; h_reg = 16'd8; gen_mode = GEN_SMALL; n_items = 120; end
            endcase

            if (p == 5) begin
                cfg_write(CFG_IDX_SPARE_B, cfg_data_t'($urandom_range(0, 65535)));
            end
            cfg_write(CFG_IDX_INIT_WIDTH, w_reg);
            cfg_write(CFG_IDX_INIT_HEIGHT, h_reg);
            set_pacing(p % 4);

            for (int i = 0; i < n_items; i++) begin
                glyph_q.push_back(random_glyph(gen_mode));
            end
            // sender keeps offering while the receiver sits on its hands
            if (p == 0) begin
                hold_req <= hold_req + 1;
            end
            drain_and_settle();
        end

        if (mismatch_cnt == 0 && placement_q.size() == 0) begin
            $display("glyph_atlas_shelf_packer_tb OK");
        end else begin
            $display("glyph_atlas_shelf_packer_tb NOT OK");
        end
        $finish;
    end

endmodule
